### src/sixp_pkg.sv
// ---------------------------------------------------------------------------
// Six-bit character pack/unpack package
// Shared types, constants and character mapping functions.
// ---------------------------------------------------------------------------
package sixp_pkg;

   localparam int ALPHA_SIZE     = 40;
   localparam int MAX_RESULTS    = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   localparam logic [2:0] ADDR_MODE    = 3'd0;

   localparam logic       MODE_PACK    = 1'b0;
   localparam logic       MODE_UNPACK  = 1'b1;
   localparam logic [7:0] NEWLINE_CHAR = 8'd10;

   localparam logic [7:0] ALPHABET [ALPHA_SIZE] = '{
      "A", "B", "C", "D", "E", "F", "G", "H", "I", "J",
      "K", "L", "M", "N", "O", "P", "Q", "R", "S", "T",
      "U", "V", "W", "X", "Y", "Z", "0", "1", "2", "3",
      "4", "5", "6", "7", "8", "9", " ", "-", "/", "&"
   };

   typedef struct packed {
      logic [1:0]                  count;
      logic [MAX_RESULTS-1:0][7:0] data;
   } entry_type;

   typedef struct packed {
      logic mode;
      logic clear;
   } cfg_type;

   function automatic logic [5:0] char_to_code(input logic [7:0] c);
      logic [5:0] code;
      code = '0;
      for (int i = 0; i < ALPHA_SIZE; i++) begin
         if (c == ALPHABET[i]) begin
            code = 6'(i + 1);
         end
      end
      return code;
   endfunction

   function automatic logic [7:0] code_to_char(input logic [5:0] code);
      logic [7:0] c;
      if (code == 6'd0) begin
         c = NEWLINE_CHAR;
      end else if (code <= 6'(ALPHA_SIZE)) begin
         c = ALPHABET[code - 6'd1];
      end else begin
         c = 8'd0;
      end
      return c;
   endfunction

endpackage

### src/sixp_front.sv
// ---------------------------------------------------------------------------
// Six-bit character pack/unpack front end
// Accepts input beats, updates the bit buffer and builds a result entry.
// ---------------------------------------------------------------------------
module sixp_front #(
   parameter int BLOCK_BITS = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  sixp_pkg::cfg_type  cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // in_byte
   input  logic               req_tlast,   // in_last
   input  logic               queue_full,
   output logic               push,
   output sixp_pkg::entry_type push_data
);

   localparam int POS_BITS = $clog2(BLOCK_BITS + 8);

   logic [12:0]         buf_ff, buf_in;
   logic [3:0]          held_ff, held_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;

   logic [12:0]         wide;
   logic [4:0]          held_t;
   logic [POS_BITS-1:0] pos_t;
   logic [7:0]          tail;
   logic [1:0]          n;
   logic [sixp_pkg::MAX_RESULTS-1:0][7:0] bytes;
   logic                accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      wide   = buf_ff;
      held_t = {1'b0, held_ff};
      pos_t  = pos_ff;
      tail   = '0;
      n      = '0;
      bytes  = '0;
      if (cfg.mode == sixp_pkg::MODE_PACK) begin
         wide   = {buf_ff[6:0], sixp_pkg::char_to_code(req_tdata)};
         held_t = held_t + 5'd6;
         if (held_t >= 5'd8) begin
            bytes[n] = 8'(wide >> (held_t - 5'd8));
            n        = n + 2'd1;
            held_t   = held_t - 5'd8;
         end
         wide = wide & ((13'd1 << held_t) - 13'd1);
         if (req_tlast && held_t != 5'd0) begin
            tail = 8'(wide << (5'd8 - held_t));
            if (tail != 8'd0) begin
               bytes[n] = tail;
               n        = n + 2'd1;
            end
         end
      end else begin
         wide   = {buf_ff[4:0], req_tdata};
         held_t = held_t + 5'd8;
         pos_t  = pos_ff + POS_BITS'(8);
         for (int k = 0; k < 2; k++) begin
            if (held_t >= 5'd6) begin
               bytes[n] = sixp_pkg::code_to_char(6'(wide >> (held_t - 5'd6)));
               n        = n + 2'd1;
               held_t   = held_t - 5'd6;
            end
         end
         wide = wide & ((13'd1 << held_t) - 13'd1);
         if (pos_t >= POS_BITS'(BLOCK_BITS)) begin
            pos_t  = '0;
            held_t = '0;
            wide   = '0;
         end
         if (req_tlast && pos_t != '0) begin
            bytes[n] = sixp_pkg::NEWLINE_CHAR;
            n        = n + 2'd1;
         end
      end
   end

   always_comb begin
      buf_in  = buf_ff;
      held_in = held_ff;
      pos_in  = pos_ff;
      if (cfg.clear) begin
         buf_in  = '0;
         held_in = '0;
         pos_in  = '0;
      end else if (accept) begin
         if (req_tlast) begin
            buf_in  = '0;
            held_in = '0;
            pos_in  = '0;
         end else begin
            buf_in  = wide;
            held_in = held_t[3:0];
            pos_in  = pos_t;
         end
      end
   end

   assign push            = accept && (n != 2'd0);
   assign push_data.count = n;
   assign push_data.data  = bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         held_ff <= '0;
         pos_ff  <= '0;
      end else begin
         buf_ff  <= buf_in;
         held_ff <= held_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

### src/sixp_fifo.sv
// ---------------------------------------------------------------------------
// Six-bit character pack/unpack entry queue
// Short queue of result entries between the front and back ends.
// ---------------------------------------------------------------------------
module sixp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sixp_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output sixp_pkg::entry_type pop_data,
   output logic                empty
);

   sixp_pkg::entry_type slots_ff [sixp_pkg::QUEUE_DEPTH];

   logic [sixp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sixp_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sixp_pkg::QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full     = (cnt_ff == sixp_pkg::QUEUE_CNT_BITS'(sixp_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sixp_pkg::QUEUE_PTR_BITS'(sixp_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sixp_pkg::QUEUE_PTR_BITS'(sixp_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### src/sixp_back.sv
// ---------------------------------------------------------------------------
// Six-bit character pack/unpack back end
// Takes entries from the queue and sends their bytes one beat at a time.
// ---------------------------------------------------------------------------
module sixp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  sixp_pkg::entry_type queue_data,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic                rsp_tlast    // out_last_of_item
);

   sixp_pkg::entry_type cur_ff, cur_in;
   logic                valid_ff, valid_in;
   logic [1:0]          idx_ff, idx_in;
   logic                accept, final_beat;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = cur_ff.data[idx_ff];
   assign final_beat = (idx_ff == cur_ff.count - 2'd1);
   assign rsp_tlast  = final_beat;
   assign accept     = valid_ff && rsp_tready;
   assign pop        = !queue_empty && (!valid_ff || (accept && final_beat));

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         cur_in   = queue_data;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (accept) begin
         if (final_beat) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### src/six_bit_char_pack_unpack_core.sv
// A result beat is registered in the queue, then in the back end's entry
// register, before it is offered. Throughput: one input beat per cycle while
// the two-entry queue has room; results (up to three per input beat) leave at
// one beat per cycle while rsp_tready is high, set by the single output port.
// Reset: mode returns to pack, the bit buffer and block count clear, the
// queue empties. A write to mode also clears the bit buffer and block count.
// ---------------------------------------------------------------------------
// Six-bit character pack/unpack core
// Packs characters into six-bit codes or unpacks codes back into characters.
// ---------------------------------------------------------------------------
module six_bit_char_pack_unpack_core #(
   parameter int BLOCK_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // in_byte
   input  logic        req_tlast,    // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // out_byte
   output logic        rsp_tlast,    // out_last_of_item
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                mode_ff, mode_in;
   logic                mode_wr;
   sixp_pkg::cfg_type   cfg;
   logic                push, pop, queue_full, queue_empty;
   sixp_pkg::entry_type push_data, pop_data;

   assign csr_pready = 1'b1;
   assign mode_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == sixp_pkg::ADDR_MODE);
   assign mode_in    = mode_wr ? csr_pwdata[0] : mode_ff;
   assign csr_prdata = (csr_paddr == sixp_pkg::ADDR_MODE) ? {31'd0, mode_ff} : 32'd0;
   assign cfg.mode   = mode_ff;
   assign cfg.clear  = mode_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sixp_pkg::MODE_PACK;
      end else begin
         mode_ff <= mode_in;
      end
   end

   sixp_front #(
      .BLOCK_BITS(BLOCK_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   sixp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   sixp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
